>>> hw/rtl/slcd_pkg.sv
// slcd_pkg: shared types, defaults and decode tables for the segment lcd mapper
// no dependencies; imported by slcd_div10, the mapper core, slcd_checker and tb_top

package slcd_pkg;

  // default build-time sizes
  localparam int DIGIT_COUNT_DEF   = 6;
  localparam int SEGMENT_LINES_DEF = 40;
  localparam int COMMON_COUNT_DEF  = 4;

  // fixed field widths
  localparam int ENTRY_W  = 4;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int QUOT_W   = 29;
  localparam int SEG_LAST = 6;

  // result of the shared divide-by-ten unit
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [3:0]        rem;
  } div_res_t;

  // seven-segment pattern, bit 0 = segment a
  function automatic logic [6:0] glyph(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'b0111111;
      4'd1:    pat = 7'b0000110;
      4'd2:    pat = 7'b1011011;
      4'd3:    pat = 7'b1001111;
      4'd4:    pat = 7'b1100110;
      4'd5:    pat = 7'b1101101;
      4'd6:    pat = 7'b1111101;
      4'd7:    pat = 7'b0000111;
      4'd8:    pat = 7'b1111111;
      4'd9:    pat = 7'b1101111;
      default: pat = 7'b0000000;
    endcase
    return pat;
  endfunction

  // segment line for (position, segment); only position 0 is wired
  function automatic logic [INDEX_W-1:0] map_line(input logic [2:0] pos,
                                                  input logic [2:0] seg);
    logic [INDEX_W-1:0] ln;
    ln = '0;
    if (pos == 3'd0) begin
      case (seg)
        3'd0:    ln = 6'd15;
        3'd1:    ln = 6'd16;
        3'd2:    ln = 6'd16;
        3'd3:    ln = 6'd15;
        3'd4:    ln = 6'd16;
        3'd5:    ln = 6'd16;
        3'd6:    ln = 6'd17;
        default: ln = '0;
      endcase
    end
    return ln;
  endfunction

  // backplane for (position, segment)
  function automatic logic [1:0] map_com(input logic [2:0] pos,
                                         input logic [2:0] seg);
    logic [1:0] cm;
    cm = '0;
    if (pos == 3'd0) begin
      case (seg)
        3'd0:    cm = 2'd0;
        3'd1:    cm = 2'd0;
        3'd2:    cm = 2'd2;
        3'd3:    cm = 2'd3;
        3'd4:    cm = 2'd3;
        3'd5:    cm = 2'd1;
        3'd6:    cm = 2'd2;
        default: cm = '0;
      endcase
    end
    return cm;
  endfunction

endpackage

>>> hw/rtl/slcd_ram.sv
// slcd_ram: generic single-write, single-read memory with registered read
// no dependencies

module slcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/slcd_div10.sv
// slcd_div10: shared divide-by-ten unit, reciprocal multiply, remainder by subtraction
// depends on slcd_pkg for the field widths and the result struct

module slcd_div10
  import slcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output div_res_t           res
);

  localparam logic [VALUE_W-1:0] Magic = 32'hCCCCCCCD;

  logic [2*VALUE_W-1:0] prod_r;
  logic [VALUE_W-1:0]   val_r;
  logic                 stg_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [3:0]           rem_r;
  logic                 done_r;

  logic [QUOT_W-1:0]    q;
  logic [VALUE_W-1:0]   q10;
  logic [VALUE_W-1:0]   diff;

  // quotient is the product shifted by 35, remainder by subtracting 10q
  always_comb begin
    q    = prod_r[2*VALUE_W-1:35];
    q10  = {q, 3'b000} + {2'b00, q, 1'b0};
    diff = val_r - q10;
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg_r  <= start;
      done_r <= stg_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= {{VALUE_W{1'b0}}, value} * {{VALUE_W{1'b0}}, Magic};
      val_r  <= value;
    end
    if (stg_r) begin
      quot_r <= q;
      rem_r  <= diff[3:0];
    end
  end

  assign res = '{done: done_r, quot: quot_r, rem: rem_r};

endmodule

>>> hw/rtl/seven_segment_lcd_ram_mapper_core.sv
// seven_segment_lcd_ram_mapper_core: display memory mapper for a 1/4-duty lcd
// depends on slcd_pkg, slcd_ram and slcd_div10
//
// input channel (in_valid/in_ready) takes one word: mode, value, position.
//   mode 0: value is split into DIGIT_COUNT decimal digits, each drawn
//           through the segment map with read-modify-write of the memory.
//   mode 1: draws digit value at position; ignored if position or digit
//           is out of range. mode 3 is ignored.
//   mode 2: dumps all SEGMENT_LINES entries on the result channel
//           (out_valid/out_ready), index order, out_last on the final one.
// in_ready is high only while the sequencer is idle; one word at a time.
// sequence: mode 0 runs a divide by ten per digit, then a read and a
//   write-back per segment through the registered ram read port; mode 1 runs
//   the read and write-back per segment only; a dump reads, loads the output
//   register and presents each entry, and starts the next once it is accepted.
// a stalled receiver holds the current entry; the dump resumes on accept.
// reset clears the per-entry valid bits, so the whole memory reads as zero
//   right after reset with no clearing pass.

module seven_segment_lcd_ram_mapper_core
  import slcd_pkg::*;
#(
  parameter int DIGIT_COUNT   = DIGIT_COUNT_DEF,
  parameter int SEGMENT_LINES = SEGMENT_LINES_DEF,
  parameter int COMMON_COUNT  = COMMON_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [2:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] out_entry_index,
  output logic [ENTRY_W-1:0] out_entry_bits,
  output logic               out_last
);

  localparam int AW = $clog2(SEGMENT_LINES);

  localparam logic [1:0] MODE_NUMBER = 2'd0;
  localparam logic [1:0] MODE_DIGIT  = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SEG_RD,
    S_SEG_WR,
    S_DUMP_RD,
    S_DUMP_LD,
    S_DUMP_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic                 mode_num_r, mode_num_nxt;
  logic [VALUE_W-1:0]   num_r, num_nxt;
  logic [3:0]           digit_r, digit_nxt;
  logic [2:0]           pos_r, pos_nxt;
  logic [2:0]           seg_r, seg_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [SEGMENT_LINES-1:0] vld_r, vld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]   out_index_r, out_index_nxt;
  logic [ENTRY_W-1:0]   out_bits_r, out_bits_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 div_start;
  div_res_t             div_res;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [INDEX_W-1:0]   seg_line;
  logic [1:0]           seg_com;
  logic [6:0]           seg_pat;
  logic                 seg_on;
  logic                 seg_hit;
  logic [AW-1:0]        seg_addr;
  logic [ENTRY_W-1:0]   cur_bits;
  logic [ENTRY_W-1:0]   bit_mask;
  logic                 seg_done;
  logic                 digit_ok;

  // divider takes the value being loaded, so a fresh number starts at once
  slcd_div10 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (num_nxt),
    .res   (div_res)
  );

  slcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SEGMENT_LINES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // segment target decode for the current position and segment
  always_comb begin
    seg_line = map_line(pos_r, seg_r);
    seg_com  = map_com(pos_r, seg_r);
    seg_pat  = glyph(digit_r);
    seg_on   = seg_pat[seg_r];
    seg_hit  = ({1'b0, seg_line} < 7'(SEGMENT_LINES)) &&
               ({1'b0, seg_com} < 3'(COMMON_COUNT));
    seg_addr = AW'(seg_line);
    bit_mask = ENTRY_W'(4'b0001 << seg_com);
    seg_done = (seg_r == 3'(SEG_LAST));
    digit_ok = ({1'b0, in_position} < 4'(DIGIT_COUNT)) && (in_value <= 32'd9);
  end

  // entries never written read as zero
  assign cur_bits = vld_r[ram_raddr] ? ram_rdata : '0;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_num_nxt  = mode_num_r;
    num_nxt       = num_r;
    digit_nxt     = digit_r;
    pos_nxt       = pos_r;
    seg_nxt       = seg_r;
    idx_nxt       = idx_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = seg_addr;
    ram_wdata     = seg_on ? (cur_bits | bit_mask) : (cur_bits & ~bit_mask);
    ram_raddr     = seg_addr;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_NUMBER: begin
              mode_num_nxt = 1'b1;
              num_nxt      = in_value;
              pos_nxt      = '0;
              state_nxt    = S_DIV;
            end
            MODE_DIGIT: begin
              if (digit_ok) begin
                mode_num_nxt = 1'b0;
                digit_nxt    = in_value[3:0];
                pos_nxt      = in_position;
                seg_nxt      = '0;
                state_nxt    = S_SEG_RD;
              end
            end
            MODE_DUMP: begin
              idx_nxt   = '0;
              state_nxt = S_DUMP_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // wait for the next decimal digit
      S_DIV: begin
        if (div_res.done) begin
          digit_nxt = div_res.rem;
          num_nxt   = VALUE_W'(div_res.quot);
          seg_nxt   = '0;
          state_nxt = S_SEG_RD;
        end
      end

      // read the target entry, or skip a target outside the memory
      S_SEG_RD: begin
        if (seg_hit) begin
          state_nxt = S_SEG_WR;
        end else if (!seg_done) begin
          seg_nxt = seg_r + 3'd1;
        end else if (mode_num_r && (pos_r != 3'(DIGIT_COUNT - 1))) begin
          pos_nxt   = pos_r + 3'd1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // write back with the segment bit set or cleared
      S_SEG_WR: begin
        ram_we            = 1'b1;
        vld_nxt[seg_addr] = 1'b1;
        if (!seg_done) begin
          seg_nxt   = seg_r + 3'd1;
          state_nxt = S_SEG_RD;
        end else if (mode_num_r && (pos_r != 3'(DIGIT_COUNT - 1))) begin
          pos_nxt   = pos_r + 3'd1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        ram_raddr = idx_r;
        state_nxt = S_DUMP_LD;
      end

      // load the output register from the ram read
      S_DUMP_LD: begin
        ram_raddr     = idx_r;
        out_valid_nxt = 1'b1;
        out_index_nxt = INDEX_W'(idx_r);
        out_bits_nxt  = cur_bits;
        out_last_nxt  = (idx_r == AW'(SEGMENT_LINES - 1));
        state_nxt     = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // launch the divider on entering a digit
    if ((state_nxt == S_DIV) && (state_r != S_DIV)) begin
      div_start = 1'b1;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      mode_num_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      mode_num_r  <= mode_num_nxt;
    end
    num_r       <= num_nxt;
    digit_r     <= digit_nxt;
    pos_r       <= pos_nxt;
    seg_r       <= seg_nxt;
    idx_r       <= idx_nxt;
    out_index_r <= out_index_nxt;
    out_bits_r  <= out_bits_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_entry_index = out_index_r;
  assign out_entry_bits  = out_bits_r;
  assign out_last        = out_last_r;

endmodule

>>> tb/slcd_tb_pkg.sv
// slcd_tb_pkg: request mode codes shared by the lcd mapper testbench files
// no dependencies; imported by slcd_checker and tb_top
`timescale 1ns / 100ps

package slcd_tb_pkg;

  // request modes of the input word
  typedef enum logic [1:0] {
    MODE_SHOW_NUMBER = 2'd0,
    MODE_SHOW_DIGIT  = 2'd1,
    MODE_DUMP        = 2'd2,
    MODE_UNUSED      = 2'd3
  } lcd_mode_e;

endpackage

>>> tb/slcd_checker.sv
// slcd_checker: mirrors the lcd display memory and checks every dumped entry
// depends on slcd_pkg (field widths, default sizes) and slcd_tb_pkg (mode codes)
`timescale 1ns / 100ps

module slcd_checker
  import slcd_pkg::*;
  import slcd_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [2:0]         in_position,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [INDEX_W-1:0] out_entry_index,
  input  logic [ENTRY_W-1:0] out_entry_bits,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending_count,
  output int                 entries_checked
);

  localparam int LINES   = SEGMENT_LINES_DEF;
  localparam int DIGITS  = DIGIT_COUNT_DEF;
  localparam int COMMONS = COMMON_COUNT_DEF;

  // segment patterns for digits 0..9, bit 0 = segment a
  localparam logic [6:0] SEG_PATTERN [10] = '{
    7'b0111111, 7'b0000110, 7'b1011011, 7'b1001111, 7'b1100110,
    7'b1101101, 7'b1111101, 7'b0000111, 7'b1111111, 7'b1101111
  };

  // wiring of digit 0, segments a..g; all other digits land on line 0 com 0
  localparam int POS0_LINE [7] = '{15, 16, 16, 15, 16, 16, 17};
  localparam int POS0_COM  [7] = '{0, 0, 2, 3, 3, 1, 2};

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [ENTRY_W-1:0] bits;
    logic               last;
  } lcd_entry_t;

  logic [ENTRY_W-1:0] lcd_image [LINES];
  lcd_entry_t         dump_queue [$];
  lcd_entry_t         expected_entry;
  lcd_entry_t         seen_entry;
  int                 mismatches;
  int                 checked;

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    entries_checked = 0;
    mismatches      = 0;
    checked         = 0;
  end

  // set or clear each segment bit of one digit, segments in order a to g
  task automatic draw_digit(input int pos, input logic [VALUE_W-1:0] digit);
    int line;
    int com;
    if (pos >= DIGITS || digit > 9) return;
    for (int seg = 0; seg < 7; seg++) begin
      if (pos == 0) begin
        line = POS0_LINE[seg];
        com  = POS0_COM[seg];
      end else begin
        line = 0;
        com  = 0;
      end
      if (line < LINES && com < COMMONS)
        lcd_image[line][com] = SEG_PATTERN[digit[3:0]][seg];
    end
  endtask

  // update the image for one accepted word, queue the entries a dump returns
  task automatic apply_word(input logic [1:0] mode, input logic [VALUE_W-1:0] value,
                            input logic [2:0] position);
    logic [VALUE_W-1:0] rest;
    lcd_entry_t         entry;
    case (mode)
      MODE_SHOW_NUMBER: begin
        rest = value;
        for (int i = 0; i < DIGITS; i++) begin
          draw_digit(i, rest % 10);
          rest = rest / 10;
        end
      end
      MODE_SHOW_DIGIT: begin
        draw_digit(int'(position), value);
      end
      MODE_DUMP: begin
        for (int i = 0; i < LINES; i++) begin
          entry.index = INDEX_W'(i);
          entry.bits  = lcd_image[i];
          entry.last  = (i == LINES - 1);
          dump_queue.push_back(entry);
        end
      end
      default: ;
    endcase
  endtask

  // watch both channels; results are checked before a new word is applied
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LINES; k++) lcd_image[k] = '0;
      dump_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen_entry.index = out_entry_index;
        seen_entry.bits  = out_entry_bits;
        seen_entry.last  = out_last;
        if (dump_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: entry %0d (bits %h last %b) arrived with no dump pending",
                     out_entry_index, out_entry_bits, out_last);
        end else begin
          expected_entry = dump_queue.pop_front();
          checked++;
          if (seen_entry !== expected_entry) begin
            mismatches++;
            if (mismatches <= 10)
              $display("checker: expected index %0d bits %h last %b, got index %0d bits %h last %b",
                       expected_entry.index, expected_entry.bits, expected_entry.last,
                       seen_entry.index, seen_entry.bits, seen_entry.last);
          end
        end
      end
      if (in_valid && in_ready) apply_word(in_mode, in_value, in_position);
    end
    fail_count      <= mismatches;
    pending_count   <= dump_queue.size();
    entries_checked <= checked;
  end

endmodule

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for seven_segment_lcd_ram_mapper_core
// depends on slcd_pkg, slcd_tb_pkg, slcd_checker and the mapper rtl
`timescale 1ns / 100ps

module tb_top;
  import slcd_pkg::*;
  import slcd_tb_pkg::*;

  localparam int RANDOM_WORDS = 300;
  localparam int CALM_WORDS   = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic [2:0]         in_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [INDEX_W-1:0] out_entry_index;
  logic [ENTRY_W-1:0] out_entry_bits;
  logic               out_last;

  int fail_count;
  int pending_count;
  int entries_checked;
  int cycle_count = 0;
  int mode_words [4] = '{0, 0, 0, 0};
  bit calm = 1'b0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  seven_segment_lcd_ram_mapper_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_index (out_entry_index),
    .out_entry_bits  (out_entry_bits),
    .out_last        (out_last)
  );

  slcd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_index (out_entry_index),
    .out_entry_bits  (out_entry_bits),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .entries_checked (entries_checked)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver: ready runs broken by stall bursts, none once calm
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // present one word, maybe after an idle burst, and hold it until accepted
  task automatic send_word(input lcd_mode_e mode, input logic [VALUE_W-1:0] value,
                           input logic [2:0] position);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_value    <= value;
    in_position <= position;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mode_words[mode]++;
  endtask

  initial begin
    lcd_mode_e          mode;
    logic [VALUE_W-1:0] value;
    logic [2:0]         position;
    int                 pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: cleared memory, number extremes, digit corners, ignored words
    send_word(MODE_DUMP, '0, '0);
    send_word(MODE_SHOW_NUMBER, 32'd0, 3'd0);
    send_word(MODE_DUMP, '0, 3'd7);
    send_word(MODE_SHOW_NUMBER, 32'hFFFF_FFFF, 3'd7);
    send_word(MODE_DUMP, 32'hFFFF_FFFF, '0);
    send_word(MODE_SHOW_NUMBER, 32'd888888, 3'd0);
    send_word(MODE_DUMP, '0, '0);
    send_word(MODE_SHOW_DIGIT, 32'd8, 3'd0);
    send_word(MODE_SHOW_DIGIT, 32'd1, 3'd5);
    send_word(MODE_DUMP, '0, '0);
    send_word(MODE_SHOW_DIGIT, 32'd3, 3'd6);
    send_word(MODE_SHOW_DIGIT, 32'd0, 3'd7);
    send_word(MODE_SHOW_DIGIT, 32'd10, 3'd0);
    send_word(MODE_SHOW_DIGIT, 32'h8000_0009, 3'd0);
    send_word(MODE_UNUSED, 32'hFFFF_FFFF, 3'd7);
    send_word(MODE_DUMP, '0, '0);
    send_word(MODE_SHOW_DIGIT, 32'd9, 3'd0);
    send_word(MODE_SHOW_DIGIT, 32'd8, 3'd5);
    send_word(MODE_SHOW_DIGIT, 32'd7, 3'd3);
    send_word(MODE_DUMP, '0, '0);
    send_word(MODE_SHOW_NUMBER, 32'd123457, 3'd2);
    send_word(MODE_DUMP, '0, '0);

    // random mix; the tail runs without idling on either side
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      pick     = $urandom_range(0, 99);
      value    = $urandom;
      position = 3'($urandom_range(0, 7));
      if (n == RANDOM_WORDS - 1 || (pick >= 70 && pick < 92)) begin
        mode = MODE_DUMP;
      end else if (pick < 35) begin
        mode = MODE_SHOW_NUMBER;
        if ($urandom_range(0, 2) == 0) value = $urandom_range(0, 999999);
      end else if (pick < 70) begin
        mode = MODE_SHOW_DIGIT;
        if ($urandom_range(0, 9) < 4) position = 3'd0;
        if ($urandom_range(0, 9) < 8) value = $urandom_range(0, 9);
        else if ($urandom_range(0, 1) == 0) value = $urandom_range(10, 15);
      end else begin
        mode = MODE_UNUSED;
      end
      send_word(mode, value, position);
    end
    in_valid <= 1'b0;

    // drain outstanding entries, then let the block settle
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d number, %0d digit, %0d dump and %0d unused-mode words sent",
             mode_words[MODE_SHOW_NUMBER], mode_words[MODE_SHOW_DIGIT],
             mode_words[MODE_DUMP], mode_words[MODE_UNUSED]);
    $display("tb_top: %0d dumped entries compared, %0d mismatches",
             entries_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/slcd_pkg.sv
hw/rtl/slcd_ram.sv
hw/rtl/slcd_div10.sv
hw/rtl/seven_segment_lcd_ram_mapper_core.sv
tb/slcd_tb_pkg.sv
tb/slcd_checker.sv
tb/tb_top.sv
